>>> design/hrk512_pkg.sv
`default_nettype none
package hrk512_pkg;

  localparam int LaneCount = 4;
  localparam int ConstCount = 40;

  typedef logic [127:0] lane_t;
  typedef lane_t [LaneCount-1:0] state_t;

  // aes s-box
  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5, 8'h30, 8'h01, 8'h67, 8'h2b,
    8'hfe, 8'hd7, 8'hab, 8'h76, 8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0, 8'hb7, 8'hfd, 8'h93, 8'h26,
    8'h36, 8'h3f, 8'hf7, 8'hcc, 8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a, 8'h07, 8'h12, 8'h80, 8'he2,
    8'heb, 8'h27, 8'hb2, 8'h75, 8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84, 8'h53, 8'hd1, 8'h00, 8'hed,
    8'h20, 8'hfc, 8'hb1, 8'h5b, 8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85, 8'h45, 8'hf9, 8'h02, 8'h7f,
    8'h50, 8'h3c, 8'h9f, 8'ha8, 8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2, 8'hcd, 8'h0c, 8'h13, 8'hec,
    8'h5f, 8'h97, 8'h44, 8'h17, 8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88, 8'h46, 8'hee, 8'hb8, 8'h14,
    8'hde, 8'h5e, 8'h0b, 8'hdb, 8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79, 8'he7, 8'hc8, 8'h37, 8'h6d,
    8'h8d, 8'hd5, 8'h4e, 8'ha9, 8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6, 8'he8, 8'hdd, 8'h74, 8'h1f,
    8'h4b, 8'hbd, 8'h8b, 8'h8a, 8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e, 8'he1, 8'hf8, 8'h98, 8'h11,
    8'h69, 8'hd9, 8'h8e, 8'h94, 8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68, 8'h41, 8'h99, 8'h2d, 8'h0f,
    8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // round constants, words 0..3 of each 128-bit key
  localparam logic [31:0] RC [ConstCount][4] = '{
    '{32'h75817b9d, 32'hb2c5fef0, 32'he620c00a, 32'h0684704c},
    '{32'h2f08f717, 32'h640f6ba4, 32'h88f3a06b, 32'h8b66b4e1},
    '{32'h9f029114, 32'hcf029d60, 32'h53f28498, 32'h3402de2d},
    '{32'hfd5b4f79, 32'hbbf3bcaf, 32'h2e7b4f08, 32'h0ed6eae6},
    '{32'hbe397044, 32'h79eecd1c, 32'h4872448b, 32'hcbcfb0cb},
    '{32'h2b8a057b, 32'h8d5335ed, 32'h6e9032b7, 32'h7eeacdee},
    '{32'hda4fef1b, 32'he2412761, 32'h5e2e7cd0, 32'h67c28f43},
    '{32'h1fc70b3b, 32'h675ffde2, 32'hafcacc07, 32'h2924d9b0},
    '{32'hb9d465ee, 32'hecdb8fca, 32'he6867fe9, 32'hab4d63f1},
    '{32'had037e33, 32'h5b2a404f, 32'hd4b7cd64, 32'h1c30bf84},
    '{32'h8df69800, 32'h69028b2e, 32'h941723bf, 32'hb2cc0bb9},
    '{32'h5c9d2d8a, 32'h4aaa9ec8, 32'hde6f5572, 32'hfa0478a6},
    '{32'h29129fd4, 32'h0efa4f2e, 32'h6b772a12, 32'hdfb49f2b},
    '{32'hbb6a12ee, 32'h32d611ae, 32'hf449a236, 32'h1ea10344},
    '{32'h9ca8eca6, 32'h5f9600c9, 32'h4b050084, 32'haf044988},
    '{32'h27e593ec, 32'h78a2c7e3, 32'h9d199c4f, 32'h21025ed8},
    '{32'h82d40173, 32'hb9282ecd, 32'ha759c9b7, 32'hbf3aaaf8},
    '{32'h10307d6b, 32'h37f2efd9, 32'h6186b017, 32'h6260700d},
    '{32'hf6fc9ac6, 32'h81c29153, 32'h21300443, 32'h5aca45c2},
    '{32'h36d1943a, 32'h2caf92e8, 32'h226b68bb, 32'h9223973c},
    '{32'he51071b4, 32'h6cbab958, 32'h225886eb, 32'hd3bf9238},
    '{32'h24e1128d, 32'h933dfddd, 32'haef0c677, 32'hdb863ce5},
    '{32'hcb2212b1, 32'h83e48de3, 32'hffeba09c, 32'hbb606268},
    '{32'hc72bf77d, 32'h2db91a4e, 32'he2e4d19c, 32'h734bd3dc},
    '{32'h2cb3924e, 32'h4b1415c4, 32'h61301b43, 32'h43bb47c3},
    '{32'h16eb6899, 32'h03b231dd, 32'he707eff6, 32'hdba775a8},
    '{32'h7eca472c, 32'h8e5e2302, 32'h3c755977, 32'h6df3614b},
    '{32'hb88617f9, 32'h6d1be5b9, 32'hd6de7d77, 32'hcda75a17},
    '{32'ha946ee5d, 32'h9d6c069d, 32'h6ba8e9aa, 32'hec6b43f0},
    '{32'h3bf327c1, 32'ha2531159, 32'hf957332b, 32'hcb1e6950},
    '{32'h600ed0d9, 32'he4ed0353, 32'h00da619c, 32'h2cee0c75},
    '{32'h63a4a350, 32'h80bbbabc, 32'h96e90cab, 32'hf0b1a5a1},
    '{32'h938dca39, 32'hab0dde30, 32'h5e962988, 32'hae3db102},
    '{32'h2e75b442, 32'h8814f3a8, 32'hd554a40b, 32'h17bb8f38},
    '{32'h360a16f6, 32'haeb6b779, 32'h5f427fd7, 32'h34bb8a5b},
    '{32'hffbaafde, 32'h43ce5918, 32'hcbe55438, 32'h26f65241},
    '{32'h839ec978, 32'ha2ca9cf7, 32'hb9f3026a, 32'h4ce99a54},
    '{32'h22901235, 32'h40c06e28, 32'h1bdff7be, 32'hae51a51a},
    '{32'h48a659cf, 32'hc173bc0f, 32'hba7ed22b, 32'ha0c1613c},
    '{32'he9c59da1, 32'h4ad6bdfd, 32'h02288288, 32'h756acc03}
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // one aes encryption round on a lane, byte i in bits 8i+7:8i
  function automatic lane_t aes_round(input lane_t x, input logic [5:0] kidx);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    lane_t y;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4 * c] = SBOX[x[8 * (r + 4 * ((c + r) % 4)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4 * c];
      a1 = t[4 * c + 1];
      a2 = t[4 * c + 2];
      a3 = t[4 * c + 3];
      y[32 * c +: 8]      = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      y[32 * c + 8 +: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      y[32 * c + 16 +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      y[32 * c + 24 +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      y[32 * c +: 32] = y[32 * c +: 32] ^ RC[kidx][c];
    end
    return y;
  endfunction

  // mix4 interleave of 32-bit words
  function automatic state_t mix4(input state_t s);
    state_t n;
    n[0] = {s[3][127:96], s[1][127:96], s[2][127:96], s[0][127:96]};
    n[1] = {s[1][31:0], s[3][31:0], s[0][31:0], s[2][31:0]};
    n[2] = {s[1][63:32], s[3][63:32], s[0][63:32], s[2][63:32]};
    n[3] = {s[3][95:64], s[1][95:64], s[2][95:64], s[0][95:64]};
    return n;
  endfunction

endpackage
`default_nettype wire

>>> design/haraka512_permutation_hash_unit.sv
`default_nettype none
// Haraka v2-512 hash of one 64-byte block into a 32-byte digest.
// Input: raise start_i with block_word0_i..block_word7_i; the word is taken
// at each edge where start_i is high and busy_o is low. busy_o is always low,
// so a new block may enter in every cycle.
// Output: done_o is high for one cycle with digest_word0_o..3_o; the receiver
// cannot stall, so no backpressure exists anywhere in the pipe.
// Path from accept to done_o: stage 0 captures the block, then 10 aes stages
// (one aes round per lane per stage), then an output register with the
// feed-forward xor. Throughput: one block per cycle, set by the unrolled
// round pipeline.
// Reset clears all stage valid bits; data registers are not reset.
module haraka512_permutation_hash_unit
  import hrk512_pkg::*;
#(
  parameter int ROUND_COUNT = 5
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [63:0] block_word0_i,
  input  wire logic [63:0] block_word1_i,
  input  wire logic [63:0] block_word2_i,
  input  wire logic [63:0] block_word3_i,
  input  wire logic [63:0] block_word4_i,
  input  wire logic [63:0] block_word5_i,
  input  wire logic [63:0] block_word6_i,
  input  wire logic [63:0] block_word7_i,
  output logic             done_o,
  output logic [63:0]      digest_word0_o,
  output logic [63:0]      digest_word1_o,
  output logic [63:0]      digest_word2_o,
  output logic [63:0]      digest_word3_o
);

  localparam int Stages = 2 * ROUND_COUNT;

  state_t blk;
  state_t st_q  [Stages+1];
  state_t blk_q [Stages+1];
  logic [Stages:0] vld_q;
  state_t fin;
  logic done_q;
  logic [63:0] dg0_q, dg1_q, dg2_q, dg3_q;

  assign busy_o = 1'b0;
  assign blk = {block_word7_i, block_word6_i, block_word5_i, block_word4_i,
                block_word3_i, block_word2_i, block_word1_i, block_word0_i};

  // stage 0 captures the block
  always_ff @(posedge clk_i) begin
    st_q[0]  <= blk;
    blk_q[0] <= blk;
  end

  // aes stages: even stage takes constants 8r+j, odd stage 8r+4+j then mix4
  for (genvar s = 0; s < Stages; s++) begin : g_stage
    state_t nxt;
    always_comb begin
      for (int j = 0; j < LaneCount; j++) begin
        nxt[j] = aes_round(st_q[s][j], 6'((s / 2) * 8 + (s % 2) * 4 + j));
      end
      if (s % 2 == 1) begin
        nxt = mix4(nxt);
      end
    end
    always_ff @(posedge clk_i) begin
      st_q[s+1]  <= nxt;
      blk_q[s+1] <= blk_q[s];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[Stages-1:0], start_i};
      done_q <= vld_q[Stages];
    end
  end

  // feed-forward xor and truncation
  always_comb begin
    for (int j = 0; j < LaneCount; j++) begin
      fin[j] = st_q[Stages][j] ^ blk_q[Stages][j];
    end
  end

  always_ff @(posedge clk_i) begin
    dg0_q <= fin[0][127:64];
    dg1_q <= fin[1][127:64];
    dg2_q <= fin[2][63:0];
    dg3_q <= fin[3][63:0];
  end

  assign done_o = done_q;
  assign digest_word0_o = dg0_q;
  assign digest_word1_o = dg1_q;
  assign digest_word2_o = dg2_q;
  assign digest_word3_o = dg3_q;

`ifndef SYNTHESIS
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Stages] |=> done_o) else $error("done lost");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[Stages] |=> !done_o) else $error("spurious done");
  a_first_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> vld_q[0]) else $error("accept lost");
`endif

endmodule
`default_nettype wire

>>> tb/tb_haraka512_permutation_hash_unit.sv
`default_nettype none
module tb_haraka512_permutation_hash_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [63:0] word_t;
  typedef word_t block_t [8];
  typedef logic [7:0] lane_bytes_t [16];
  typedef struct packed {
    word_t d0;
    word_t d1;
    word_t d2;
    word_t d3;
  } digest_t;

  localparam int NumRounds = 5;
  localparam int NumRandom = 1950;
  localparam int Latency = 2 * NumRounds + 1;

  // haraka round keys, four 32-bit words per key
  localparam logic [31:0] RoundKey [40][4] = '{
    '{32'h75817b9d, 32'hb2c5fef0, 32'he620c00a, 32'h0684704c},
    '{32'h2f08f717, 32'h640f6ba4, 32'h88f3a06b, 32'h8b66b4e1},
    '{32'h9f029114, 32'hcf029d60, 32'h53f28498, 32'h3402de2d},
    '{32'hfd5b4f79, 32'hbbf3bcaf, 32'h2e7b4f08, 32'h0ed6eae6},
    '{32'hbe397044, 32'h79eecd1c, 32'h4872448b, 32'hcbcfb0cb},
    '{32'h2b8a057b, 32'h8d5335ed, 32'h6e9032b7, 32'h7eeacdee},
    '{32'hda4fef1b, 32'he2412761, 32'h5e2e7cd0, 32'h67c28f43},
    '{32'h1fc70b3b, 32'h675ffde2, 32'hafcacc07, 32'h2924d9b0},
    '{32'hb9d465ee, 32'hecdb8fca, 32'he6867fe9, 32'hab4d63f1},
    '{32'had037e33, 32'h5b2a404f, 32'hd4b7cd64, 32'h1c30bf84},
    '{32'h8df69800, 32'h69028b2e, 32'h941723bf, 32'hb2cc0bb9},
    '{32'h5c9d2d8a, 32'h4aaa9ec8, 32'hde6f5572, 32'hfa0478a6},
    '{32'h29129fd4, 32'h0efa4f2e, 32'h6b772a12, 32'hdfb49f2b},
    '{32'hbb6a12ee, 32'h32d611ae, 32'hf449a236, 32'h1ea10344},
    '{32'h9ca8eca6, 32'h5f9600c9, 32'h4b050084, 32'haf044988},
    '{32'h27e593ec, 32'h78a2c7e3, 32'h9d199c4f, 32'h21025ed8},
    '{32'h82d40173, 32'hb9282ecd, 32'ha759c9b7, 32'hbf3aaaf8},
    '{32'h10307d6b, 32'h37f2efd9, 32'h6186b017, 32'h6260700d},
    '{32'hf6fc9ac6, 32'h81c29153, 32'h21300443, 32'h5aca45c2},
    '{32'h36d1943a, 32'h2caf92e8, 32'h226b68bb, 32'h9223973c},
    '{32'he51071b4, 32'h6cbab958, 32'h225886eb, 32'hd3bf9238},
    '{32'h24e1128d, 32'h933dfddd, 32'haef0c677, 32'hdb863ce5},
    '{32'hcb2212b1, 32'h83e48de3, 32'hffeba09c, 32'hbb606268},
    '{32'hc72bf77d, 32'h2db91a4e, 32'he2e4d19c, 32'h734bd3dc},
    '{32'h2cb3924e, 32'h4b1415c4, 32'h61301b43, 32'h43bb47c3},
    '{32'h16eb6899, 32'h03b231dd, 32'he707eff6, 32'hdba775a8},
    '{32'h7eca472c, 32'h8e5e2302, 32'h3c755977, 32'h6df3614b},
    '{32'hb88617f9, 32'h6d1be5b9, 32'hd6de7d77, 32'hcda75a17},
    '{32'ha946ee5d, 32'h9d6c069d, 32'h6ba8e9aa, 32'hec6b43f0},
    '{32'h3bf327c1, 32'ha2531159, 32'hf957332b, 32'hcb1e6950},
    '{32'h600ed0d9, 32'he4ed0353, 32'h00da619c, 32'h2cee0c75},
    '{32'h63a4a350, 32'h80bbbabc, 32'h96e90cab, 32'hf0b1a5a1},
    '{32'h938dca39, 32'hab0dde30, 32'h5e962988, 32'hae3db102},
    '{32'h2e75b442, 32'h8814f3a8, 32'hd554a40b, 32'h17bb8f38},
    '{32'h360a16f6, 32'haeb6b779, 32'h5f427fd7, 32'h34bb8a5b},
    '{32'hffbaafde, 32'h43ce5918, 32'hcbe55438, 32'h26f65241},
    '{32'h839ec978, 32'ha2ca9cf7, 32'hb9f3026a, 32'h4ce99a54},
    '{32'h22901235, 32'h40c06e28, 32'h1bdff7be, 32'hae51a51a},
    '{32'h48a659cf, 32'hc173bc0f, 32'hba7ed22b, 32'ha0c1613c},
    '{32'he9c59da1, 32'h4ad6bdfd, 32'h02288288, 32'h756acc03}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  word_t block_words [8];
  logic busy_o;
  logic done_o;
  word_t digest_word0_o, digest_word1_o, digest_word2_o, digest_word3_o;

  logic [7:0] sbox_lut [256];
  digest_t digest_queue [$];
  int err_count = 0;
  logic word_taken = 1'b0;

  initial begin
    for (int i = 0; i < 8; i++) begin
      block_words[i] = '0;
    end
  end

  always #4 clk_i = ~clk_i;

  haraka512_permutation_hash_unit #(.ROUND_COUNT(NumRounds)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .block_word0_i (block_words[0]),
    .block_word1_i (block_words[1]),
    .block_word2_i (block_words[2]),
    .block_word3_i (block_words[3]),
    .block_word4_i (block_words[4]),
    .block_word5_i (block_words[5]),
    .block_word6_i (block_words[6]),
    .block_word7_i (block_words[7]),
    .done_o        (done_o),
    .digest_word0_o(digest_word0_o),
    .digest_word1_o(digest_word1_o),
    .digest_word2_o(digest_word2_o),
    .digest_word3_o(digest_word3_o)
  );

  // gf(2^8) product over the aes polynomial
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // s-box entry: field inverse then affine map
  function automatic logic [7:0] sbox_entry(input logic [7:0] x);
    logic [7:0] inv, base;
    inv = 8'h01;
    base = x;
    for (int e = 254; e != 0; e >>= 1) begin
      if (e & 1) inv = gf_mul(inv, base);
      base = gf_mul(base, base);
    end
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]} ^
           {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  // shiftrows, subbytes, mixcolumns, key xor on one lane
  function automatic lane_bytes_t enc_round(input lane_bytes_t ln, input int kidx);
    lane_bytes_t t, y;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4 * c] = sbox_lut[ln[r + 4 * ((c + r) % 4)]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      y[4*c]   = gf_mul(t[4*c], 8'h02) ^ gf_mul(t[4*c+1], 8'h03) ^ t[4*c+2] ^ t[4*c+3];
      y[4*c+1] = t[4*c] ^ gf_mul(t[4*c+1], 8'h02) ^ gf_mul(t[4*c+2], 8'h03) ^ t[4*c+3];
      y[4*c+2] = t[4*c] ^ t[4*c+1] ^ gf_mul(t[4*c+2], 8'h02) ^ gf_mul(t[4*c+3], 8'h03);
      y[4*c+3] = gf_mul(t[4*c], 8'h03) ^ t[4*c+1] ^ t[4*c+2] ^ gf_mul(t[4*c+3], 8'h02);
    end
    for (int i = 0; i < 16; i++) begin
      y[i] ^= RoundKey[kidx][i / 4][8 * (i % 4) +: 8];
    end
    return y;
  endfunction

  // full haraka-512 digest of one block
  function automatic digest_t haraka_digest(input block_t blk);
    lane_bytes_t lanes [4];
    lane_bytes_t orig [4];
    logic [31:0] w [4][4];
    logic [31:0] n [4][4];
    digest_t d;
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 16; i++) begin
        lanes[k][i] = blk[2 * k + i / 8][8 * (i % 8) +: 8];
      end
    end
    orig = lanes;
    for (int r = 0; r < NumRounds; r++) begin
      for (int k = 0; k < 4; k++) begin
        lanes[k] = enc_round(lanes[k], 8 * r + k);
        lanes[k] = enc_round(lanes[k], 8 * r + 4 + k);
      end
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 4; j++) begin
          w[k][j] = {lanes[k][4*j+3], lanes[k][4*j+2], lanes[k][4*j+1], lanes[k][4*j]};
        end
      end
      n[0] = '{w[0][3], w[2][3], w[1][3], w[3][3]};
      n[1] = '{w[2][0], w[0][0], w[3][0], w[1][0]};
      n[2] = '{w[2][1], w[0][1], w[3][1], w[1][1]};
      n[3] = '{w[0][2], w[2][2], w[1][2], w[3][2]};
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 4; j++) begin
          for (int i = 0; i < 4; i++) begin
            lanes[k][4 * j + i] = n[k][j][8 * i +: 8];
          end
        end
      end
    end
    d = '0;
    for (int i = 0; i < 8; i++) begin
      d.d0[8*i +: 8] = lanes[0][8 + i] ^ orig[0][8 + i];
      d.d1[8*i +: 8] = lanes[1][8 + i] ^ orig[1][8 + i];
      d.d2[8*i +: 8] = lanes[2][i] ^ orig[2][i];
      d.d3[8*i +: 8] = lanes[3][i] ^ orig[3][i];
    end
    return d;
  endfunction

  // accept tracking and digest checking
  always @(posedge clk_i) begin
    digest_t exp_d, got_d;
    word_taken = rst_ni && start_i && !busy_o;
    if (rst_ni && done_o) begin
      got_d = '{digest_word0_o, digest_word1_o, digest_word2_o, digest_word3_o};
      if (digest_queue.size() == 0) begin
        $display("%0t: unexpected digest %h", $time, got_d);
        err_count++;
      end else begin
        exp_d = digest_queue.pop_front();
        if (got_d.d0 !== exp_d.d0) begin
          $display("%0t: digest_word0 exp %h got %h", $time, exp_d.d0, got_d.d0);
          err_count++;
        end
        if (got_d.d1 !== exp_d.d1) begin
          $display("%0t: digest_word1 exp %h got %h", $time, exp_d.d1, got_d.d1);
          err_count++;
        end
        if (got_d.d2 !== exp_d.d2) begin
          $display("%0t: digest_word2 exp %h got %h", $time, exp_d.d2, got_d.d2);
          err_count++;
        end
        if (got_d.d3 !== exp_d.d3) begin
          $display("%0t: digest_word3 exp %h got %h", $time, exp_d.d3, got_d.d3);
          err_count++;
        end
      end
    end
    if (word_taken) begin
      digest_queue.push_back(haraka_digest(block_words));
    end
  end

  // drive one block at a falling edge and hold it until taken
  task automatic send_block(input block_t blk);
    start_i = 1'b1;
    block_words = blk;
    do @(negedge clk_i); while (!word_taken);
  endtask

  task automatic maybe_idle(input bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      start_i = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
  endtask

  function automatic word_t rand_word(input int unsigned style);
    word_t v;
    v = {$urandom, $urandom};
    case (style)
      0: v = v & {$urandom, $urandom} & {$urandom, $urandom};
      1: v = v | {$urandom, $urandom} | {$urandom, $urandom};
      2: v = ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: ;
    endcase
    return v;
  endfunction

  block_t directed_rows [$];

  initial begin
    block_t blk;
    for (int i = 0; i < 256; i++) begin
      sbox_lut[i] = sbox_entry(i[7:0]);
    end

    // directed stimulus table
    blk = '{default: '0};
    directed_rows.push_back(blk);
    blk = '{default: '1};
    directed_rows.push_back(blk);
    blk = '{default: 64'h5555_5555_5555_5555};
    directed_rows.push_back(blk);
    blk = '{default: 64'haaaa_aaaa_aaaa_aaaa};
    directed_rows.push_back(blk);
    for (int i = 0; i < 8; i++) begin
      for (int b = 0; b < 8; b++) blk[i][8*b +: 8] = 8'(8 * i + b);
    end
    directed_rows.push_back(blk);
    blk = '{default: '0};
    blk[0] = 64'h1;
    directed_rows.push_back(blk);
    blk = '{default: '0};
    blk[7] = 64'h8000_0000_0000_0000;
    directed_rows.push_back(blk);
    for (int k = 0; k < 8; k++) begin
      blk = '{default: '0};
      blk[k] = '1;
      directed_rows.push_back(blk);
    end
    blk = '{default: '1};
    blk[3] = '0;
    directed_rows.push_back(blk);

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[r]) begin
      send_block(directed_rows[r]);
    end
    start_i = 1'b0;
    wait (digest_queue.size() == 0);
    @(negedge clk_i);

    // random blocks, idle bursts except in the last stretch
    for (int n = 0; n < NumRandom; n++) begin
      for (int i = 0; i < 8; i++) blk[i] = rand_word($urandom_range(0, 5));
      send_block(blk);
      maybe_idle(n < NumRandom - 300);
      if (n == NumRandom / 2) begin
        start_i = 1'b0;
        wait (digest_queue.size() == 0);
        @(negedge clk_i);
      end
    end
    start_i = 1'b0;

    wait (digest_queue.size() == 0);
    repeat (Latency + 5) @(posedge clk_i);
    if (err_count == 0 && digest_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire

>>> haraka512_permutation_hash_unit.f
design/hrk512_pkg.sv
design/haraka512_permutation_hash_unit.sv
tb/tb_haraka512_permutation_hash_unit.sv
